// ===== hw/rtl/mcr_pkg.sv =====
// Shared types, constants and helpers for the midpoint circle rasterizer.
// No dependencies; every other file refers to it by scoped names.
package mcr_pkg;

    // Field sizes
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int PIX_BITS    = COORD_BITS + 2;
    localparam int OFS_BITS    = RADIUS_BITS + 2;
    localparam int DEC_BITS    = RADIUS_BITS + 5;
    localparam int SUM_BITS    = ((COORD_BITS + 1 > OFS_BITS) ? COORD_BITS + 1 : OFS_BITS) + 1;

    // Pixels per step and pixel index width
    localparam int PIXELS_PER_STEP = 8;
    localparam int IDX_BITS        = $clog2(PIXELS_PER_STEP);

    // Depth of the job queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // Item opcodes
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // One step's worth of work for the back part
    typedef struct packed {
        logic        [COORD_BITS-1:0] cx;
        logic        [COORD_BITS-1:0] cy;
        logic signed [OFS_BITS-1:0]   x;
        logic signed [OFS_BITS-1:0]   y;
        logic                         fin;
    } job_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Centre plus or minus an offset, wrapped to the pixel width
    function automatic logic [PIX_BITS-1:0] pix_sum(
        input logic        [COORD_BITS-1:0] c,
        input logic signed [OFS_BITS-1:0]   off,
        input logic                         neg
    );
        logic signed [SUM_BITS-1:0] cw;
        logic signed [SUM_BITS-1:0] ow;
        logic signed [SUM_BITS-1:0] s;
        begin
            cw = signed'(SUM_BITS'(c));
            ow = SUM_BITS'(off);
            s  = neg ? (cw - ow) : (cw + ow);
            return s[PIX_BITS-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/mcr_front.sv =====
// Front part: accepts items, holds the circle state and runs the
// midpoint decision update, pushing one job per drawing step. Uses mcr_pkg.
module mcr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [0:0]                      opcode,
    input  logic [mcr_pkg::COORD_BITS-1:0]  center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]  center_y,
    input  logic [mcr_pkg::RADIUS_BITS-1:0] radius,
    input  mcr_pkg::q_status_t              q_stat,
    output logic                            push,
    output mcr_pkg::job_t                   push_job
);

    logic        [mcr_pkg::COORD_BITS-1:0] cx_reg, cx_next;
    logic        [mcr_pkg::COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [mcr_pkg::OFS_BITS-1:0]   x_reg, x_next;
    logic signed [mcr_pkg::OFS_BITS-1:0]   y_reg, y_next;
    logic signed [mcr_pkg::DEC_BITS-1:0]   d_reg, d_next;
    logic                                  active_reg, active_next;

    logic                                  accept;
    logic signed [mcr_pkg::DEC_BITS-1:0]   x_w;
    logic signed [mcr_pkg::DEC_BITS-1:0]   diff_w;
    logic signed [mcr_pkg::DEC_BITS-1:0]   r_w;

    // Stall whenever the job queue has no room
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    assign x_w    = mcr_pkg::DEC_BITS'(x_reg);
    assign diff_w = mcr_pkg::DEC_BITS'(x_reg) - mcr_pkg::DEC_BITS'(y_reg);
    assign r_w    = signed'(mcr_pkg::DEC_BITS'(radius));

    // Decision update and job build
    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        active_next = active_reg;
        push        = 1'b0;
        if (accept) begin
            if (opcode == mcr_pkg::OP_START) begin
                cx_next     = center_x;
                cy_next     = center_y;
                x_next      = '0;
                y_next      = signed'(mcr_pkg::OFS_BITS'(radius));
                d_next      = mcr_pkg::DEC_BITS'(3) - (r_w <<< 1);
                active_next = 1'b1;
            end else if (active_reg) begin
                if (x_reg > y_reg) begin
                    active_next = 1'b0;
                end else begin
                    if (d_reg <= 0) begin
                        d_next = d_reg + (x_w <<< 2) + mcr_pkg::DEC_BITS'(6);
                    end else begin
                        d_next = d_reg + (diff_w <<< 2) + mcr_pkg::DEC_BITS'(10);
                        y_next = y_reg - mcr_pkg::OFS_BITS'(1);
                    end
                    x_next = x_reg + mcr_pkg::OFS_BITS'(1);
                    push   = 1'b1;
                end
            end
        end
        push_job.cx  = cx_reg;
        push_job.cy  = cy_reg;
        push_job.x   = x_next;
        push_job.y   = y_next;
        push_job.fin = (x_next > y_next);
    end

    // Circle state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            active_reg <= 1'b0;
        end else begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            d_reg      <= d_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== hw/rtl/mcr_queue.sv =====
// Short job queue between the front and back parts of the rasterizer.
// Flip-flop storage, depth from mcr_pkg::QDEPTH. Uses mcr_pkg.
module mcr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mcr_pkg::job_t      push_job,
    input  logic               pop,
    output mcr_pkg::job_t      head,
    output mcr_pkg::q_status_t q_stat
);

    mcr_pkg::job_t                   mem_reg [mcr_pkg::QDEPTH];
    logic [mcr_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mcr_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mcr_pkg::QCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == mcr_pkg::QCNT_BITS'(mcr_pkg::QDEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == mcr_pkg::QPTR_BITS'(mcr_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + mcr_pkg::QPTR_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == mcr_pkg::QPTR_BITS'(mcr_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + mcr_pkg::QPTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + mcr_pkg::QCNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - mcr_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/mcr_back.sv =====
// Back part: takes one job from the queue and sends its eight symmetric
// pixels, one per cycle while out_stall is low, through an output register. Uses mcr_pkg.
module mcr_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcr_pkg::job_t                       head,
    input  mcr_pkg::q_status_t                  q_stat,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y,
    output logic                                color_group,
    output logic                                last,
    output logic                                finished
);

    mcr_pkg::job_t                   job_reg, job_next;
    logic [mcr_pkg::IDX_BITS-1:0]    idx_reg, idx_next;
    logic                            busy_reg, busy_next;
    logic                            ov_reg, ov_next;
    logic [mcr_pkg::PIX_BITS-1:0]    px_reg, px_next;
    logic [mcr_pkg::PIX_BITS-1:0]    py_reg, py_next;
    logic                            grp_reg, grp_next;
    logic                            last_reg, last_next;
    logic                            fin_reg, fin_next;

    logic                            load;
    logic                            emit;
    logic                            is_last;
    logic signed [mcr_pkg::OFS_BITS-1:0] col_off;
    logic signed [mcr_pkg::OFS_BITS-1:0] row_off;

    assign load    = !ov_reg || !out_stall;
    assign emit    = load && busy_reg;
    assign is_last = (idx_reg == mcr_pkg::IDX_BITS'(mcr_pkg::PIXELS_PER_STEP - 1));
    assign pop     = !q_stat.empty && (!busy_reg || (emit && is_last));

    // Red group uses (x, y), white group swaps them
    assign col_off = idx_reg[2] ? job_reg.y : job_reg.x;
    assign row_off = idx_reg[2] ? job_reg.x : job_reg.y;

    // Walk the octants and refill from the queue
    always_comb
    begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        ov_next   = ov_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        grp_next  = grp_reg;
        last_next = last_reg;
        fin_next  = fin_reg;
        if (load) begin
            ov_next = emit;
        end
        if (emit) begin
            px_next   = mcr_pkg::pix_sum(job_reg.cx, col_off, idx_reg[1]);
            py_next   = mcr_pkg::pix_sum(job_reg.cy, row_off, idx_reg[0]);
            grp_next  = idx_reg[2];
            last_next = is_last;
            fin_next  = is_last && job_reg.fin;
            idx_next  = idx_reg + mcr_pkg::IDX_BITS'(1);
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            job_next  = head;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        grp_reg  <= grp_next;
        last_reg <= last_next;
        fin_reg  <= fin_next;
    end

    assign out_valid   = ov_reg;
    assign pixel_x     = signed'(px_reg);
    assign pixel_y     = signed'(py_reg);
    assign color_group = grp_reg;
    assign last        = last_reg;
    assign finished    = fin_reg;

endmodule

// ===== hw/rtl/midpoint_circle_rasterizer_top.sv =====
// Top level of the midpoint circle rasterizer: front, job queue, back.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_stall  | opcode, center_x, center_y, radius
//  out     | out_valid/out_stall| pixel_x, pixel_y, color_group, last, finished
//
// A start item, or a step that draws nothing, is handled in the front alone.
// A drawing step sends eight pixels from the back, one pixel per cycle through the
// output register while out_stall is low; the back takes its next job as it sends the last.
// A queue of two jobs lets the front keep accepting while the back drains.
// Reset is asynchronous and active low and clears all control state at once.
// in_stall rises only when the job queue is full.
module midpoint_circle_rasterizer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [0:0]                          opcode,
    input  logic [mcr_pkg::COORD_BITS-1:0]      center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]      center_y,
    input  logic [mcr_pkg::RADIUS_BITS-1:0]     radius,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y,
    output logic                                color_group,
    output logic                                last,
    output logic                                finished
);

    mcr_pkg::q_status_t q_stat;
    mcr_pkg::job_t      push_job;
    mcr_pkg::job_t      head;
    logic               push;
    logic               pop;

    mcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    mcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    mcr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color_group (color_group),
        .last        (last),
        .finished    (finished)
    );

endmodule

// ===== hw/rtl/mcr_checker.sv =====
// Port-level checks for the midpoint circle rasterizer, bound to the top.
// Depends on mcr_pkg and midpoint_circle_rasterizer_top.
module mcr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x,
    input logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y,
    input logic                                color_group,
    input logic                                last,
    input logic                                finished
);

    // Hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(last))
        else $error("stalled output word changed");

    // Finish only on the closing pixel of a step
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> last)
        else $error("finished without last");

    // Closing pixel belongs to the white group
    a_last_white: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> color_group)
        else $error("last pixel not in white group");

    // Pixels of one step follow without gaps, white never before red
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid
            && (color_group || !$past(color_group)))
        else $error("gap or group order broken inside a step");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (.*);
